FILE: src/plf_pkg.sv
// Package for the PID line follower with search: item, config and command types,
// drive packing helpers and constants. No dependencies.
`default_nettype none
package plf_pkg;

    localparam int SPEED_LIMIT = 130;
    localparam int SAMPLE_BITS = 10;
    localparam int NUM_W       = 54;
    localparam int DEN_W       = 37;
    localparam int DVD_W       = NUM_W - 1;
    localparam int DIV_STEPS   = DVD_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam logic [31:0] LOST_MS    = 32'd1000;
    localparam logic [31:0] MAX_DT     = 32'd1000;
    localparam logic [9:0]  DEFAULT_DT = 10'd20;
    localparam logic [31:0] SPIN_R_MS  = 32'd200;
    localparam logic [31:0] SPIN_L_MS  = 32'd1600;
    localparam logic [31:0] BACKUP_MS  = 32'd2000;
    localparam logic signed [17:0] INTEG_MAX = 18'sd100000;
    localparam logic signed [17:0] INTEG_MIN = -18'sd100000;

    localparam logic [2:0] CFG_GAIN_P    = 3'd0;
    localparam logic [2:0] CFG_GAIN_I    = 3'd1;
    localparam logic [2:0] CFG_GAIN_D    = 3'd2;
    localparam logic [2:0] CFG_BASE      = 3'd3;
    localparam logic [2:0] CFG_THRESHOLD = 3'd4;
    localparam logic [2:0] CFG_LIGHTER   = 3'd5;
    localparam logic [2:0] CFG_SEARCH    = 3'd6;

    typedef enum logic [2:0] {
        MODE_HALT   = 3'd0,
        MODE_FIRST  = 3'd1,
        MODE_PID    = 3'd2,
        MODE_SPIN_R = 3'd3,
        MODE_SPIN_L = 3'd4,
        MODE_BACKUP = 3'd5,
        MODE_HELD   = 3'd6
    } drive_mode_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_left;
        logic [SAMPLE_BITS-1:0] sample_middle;
        logic [SAMPLE_BITS-1:0] sample_right;
        logic [31:0]            now_ms;
        logic                   run_enable;
    } in_item_t;

    typedef struct packed {
        logic       left_forward;
        logic [7:0] left_level;
        logic       right_forward;
        logic [7:0] right_level;
        logic [2:0] drive_mode;
    } out_item_t;

    typedef struct packed {
        logic       lf;
        logic [7:0] ll;
        logic       rf;
        logic [7:0] rl;
    } held_t;

    typedef struct packed {
        logic [23:0]            gain_p;
        logic [23:0]            gain_i;
        logic [23:0]            gain_d;
        logic [7:0]             base_speed;
        logic [SAMPLE_BITS-1:0] line_threshold;
        logic                   line_is_lighter;
        logic                   search_enable;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_EVAL, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6,
        OP_M7, OP_M8, OP_DIV_INIT, OP_DIV, OP_FIN
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EVAL, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
        ST_M8, ST_DIV_INIT, ST_DIV, ST_FIN, ST_DONE
    } state_t;

    typedef struct packed {
        op_t  op;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic pid_path;
        logic out_free;
    } status_t;

    function automatic logic [7:0] level_of(logic signed [10:0] v);
        logic [10:0] a;
        a = v[10] ? 11'(-v) : 11'(v);
        return (a > 11'(SPEED_LIMIT)) ? 8'(SPEED_LIMIT) : a[7:0];
    endfunction

    function automatic held_t drive_pack(logic signed [10:0] sl, logic signed [10:0] sr);
        held_t h;
        h.lf = ~sl[10];
        h.ll = level_of(sl);
        h.rf = ~sr[10];
        h.rl = level_of(sr);
        return h;
    endfunction

    function automatic out_item_t make_out(held_t h, drive_mode_t md);
        out_item_t o;
        o.left_forward  = h.lf;
        o.left_level    = h.ll;
        o.right_forward = h.rf;
        o.right_level   = h.rl;
        o.drive_mode    = md;
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: src/plf_ctrl.sv
// Sequencer for the line follower: walks evaluate, multiply, divide and deliver steps.
// Depends on plf_pkg.
`default_nettype none
module plf_ctrl import plf_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.push   = 1'b0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.op     = OP_EVAL;
                state_next = status.pid_path ? ST_M1 : ST_DONE;
            end
            ST_M1: begin cmd.op = OP_M1; state_next = ST_M2; end
            ST_M2: begin cmd.op = OP_M2; state_next = ST_M3; end
            ST_M3: begin cmd.op = OP_M3; state_next = ST_M4; end
            ST_M4: begin cmd.op = OP_M4; state_next = ST_M5; end
            ST_M5: begin cmd.op = OP_M5; state_next = ST_M6; end
            ST_M6: begin cmd.op = OP_M6; state_next = ST_M7; end
            ST_M7: begin cmd.op = OP_M7; state_next = ST_M8; end
            ST_M8: begin cmd.op = OP_M8; state_next = ST_DIV_INIT; end
            ST_DIV_INIT: begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin cmd.op = OP_FIN; state_next = ST_DONE; end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/plf_datapath.sv
// Datapath: line detection, search timing, PID state, multiply steps, restoring
// divider and output register. Depends on plf_pkg.
`default_nettype none
module plf_datapath import plf_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire in_item_t s_item,
    input  wire cmd_t     cmd,
    output status_t       status,
    output logic          m_valid,
    output out_item_t     m_item,
    input  wire logic     m_ready
);

    in_item_t item_reg, item_next;
    out_item_t res_reg, res_next, m_item_reg;
    logic m_valid_reg;

    logic signed [2:0]  prev_reg, prev_next;
    logic signed [17:0] acc_reg, acc_next;
    logic [31:0] last_reg, last_next, lost_since_reg, lost_since_next, start_reg, start_next;
    logic have_reg, have_next, search_reg, search_next, lost_timing_reg, lost_timing_next;
    held_t held_reg, held_next;

    logic signed [2:0]  ew_reg, ew_next;
    logic signed [3:0]  dew_reg, dew_next;
    logic [9:0]         dtw_reg, dtw_next;
    logic signed [23:0] a_reg, a_next;
    logic signed [42:0] b_reg, b_next;
    logic signed [28:0] c_reg, c_next;
    logic signed [NUM_W-1:0] t_reg, t_next, num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic neg_reg, neg_next;

    logic ln, mn, rn;
    logic [1:0] cnt;
    logic signed [10:0] bs;

    function automatic logic on_line(logic [SAMPLE_BITS-1:0] v, cfg_t c);
        return c.line_is_lighter ? (v >= c.line_threshold) : (v < c.line_threshold);
    endfunction

    assign ln  = on_line(item_reg.sample_left, cfg);
    assign mn  = on_line(item_reg.sample_middle, cfg);
    assign rn  = on_line(item_reg.sample_right, cfg);
    assign cnt = 2'(ln) + 2'(mn) + 2'(rn);
    assign bs  = $signed({3'b000, cfg.base_speed});

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        logic [31:0] lost_start, el, dt_raw;
        logic [9:0] dt;
        logic trig, go_pid;
        logic signed [2:0] e;
        logic signed [13:0] ed;
        logic signed [18:0] asum;
        logic signed [47:0] pa;
        logic signed [48:0] pt;
        logic signed [53:0] pb;
        logic signed [49:0] pc;
        logic [DEN_W:0] rem_sh;
        logic [8:0] qs;
        logic signed [10:0] corr, ls, rs;
        held_t hd;

        item_next = item_reg; res_next = res_reg;
        prev_next = prev_reg; acc_next = acc_reg; last_next = last_reg;
        lost_since_next = lost_since_reg; start_next = start_reg;
        have_next = have_reg; search_next = search_reg; lost_timing_next = lost_timing_reg;
        held_next = held_reg;
        ew_next = ew_reg; dew_next = dew_reg; dtw_next = dtw_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; t_next = t_reg; num_next = num_reg;
        den_next = den_reg; dvd_next = dvd_reg; rem_next = rem_reg; neg_next = neg_reg;
        status.pid_path = 1'b0;
        status.out_free = ~m_valid_reg | m_ready;
        lost_start = '0; el = '0; dt_raw = '0; dt = '0; trig = 1'b0; go_pid = 1'b0;
        e = '0; ed = '0; asum = '0; pa = '0; pt = '0; pb = '0; pc = '0; rem_sh = '0;
        qs = '0; corr = '0; ls = '0; rs = '0; hd = '0;

        unique case (cmd.op)
            OP_NONE: ;
            OP_LOAD: item_next = s_item;
            OP_EVAL: begin
                if (!item_reg.run_enable) begin
                    acc_next = '0; prev_next = '0; have_next = 1'b0; search_next = 1'b0;
                    hd = drive_pack(11'sd0, 11'sd0);
                    held_next = hd;
                    res_next  = make_out(hd, MODE_HALT);
                end else begin
                    go_pid = 1'b1;
                    if (cfg.search_enable) begin
                        if (cnt == 2'd0) begin
                            if (!search_reg) begin
                                lost_start = lost_timing_reg ? lost_since_reg : item_reg.now_ms;
                                lost_since_next  = lost_start;
                                lost_timing_next = 1'b1;
                                if (item_reg.now_ms - lost_start > LOST_MS) begin
                                    trig = 1'b1;
                                    acc_next = '0; prev_next = '0; have_next = 1'b0;
                                    search_next = 1'b1;
                                    start_next  = item_reg.now_ms;
                                end
                            end
                            if (search_reg || trig) begin
                                go_pid = 1'b0;
                                el = trig ? 32'd0 : item_reg.now_ms - start_reg;
                                priority if (el < SPIN_R_MS) begin
                                    hd = drive_pack(bs + 11'sd30, -(bs + 11'sd30));
                                    held_next = hd;
                                    res_next  = make_out(hd, MODE_SPIN_R);
                                end else if (el < SPIN_L_MS) begin
                                    hd = drive_pack(-(bs + 11'sd20), bs + 11'sd20);
                                    held_next = hd;
                                    res_next  = make_out(hd, MODE_SPIN_L);
                                end else if (el < BACKUP_MS) begin
                                    hd = drive_pack(-(bs + 11'sd20), -(bs + 11'sd20));
                                    held_next = hd;
                                    res_next  = make_out(hd, MODE_BACKUP);
                                end else begin
                                    res_next = make_out(held_reg, MODE_HELD);
                                end
                            end
                        end else begin
                            lost_timing_next = 1'b0;
                            search_next      = 1'b0;
                        end
                    end
                    if (go_pid) begin
                        unique case (cnt)
                            2'd0: e = prev_reg;
                            2'd1: e = rn ? 3'sd2 : (ln ? -3'sd2 : 3'sd0);
                            2'd2: e = (rn & ~ln) ? 3'sd1 : ((ln & ~rn) ? -3'sd1 : 3'sd0);
                            2'd3: e = 3'sd0;
                            default: e = 3'sd0;
                        endcase
                        if (!have_reg) begin
                            have_next = 1'b1;
                            last_next = item_reg.now_ms;
                            prev_next = e;
                            hd = drive_pack(bs, bs);
                            held_next = hd;
                            res_next  = make_out(hd, MODE_FIRST);
                        end else begin
                            status.pid_path = 1'b1;
                            dt_raw = item_reg.now_ms - last_reg;
                            dt = (dt_raw == 32'd0 || dt_raw > MAX_DT) ? DEFAULT_DT : dt_raw[9:0];
                            last_next = item_reg.now_ms;
                            ed = e * $signed({1'b0, dt});
                            asum = 19'(acc_reg) + 19'(ed);
                            if (e == 3'sd0) begin
                                acc_next = '0;
                            end else if (asum > 19'(INTEG_MAX)) begin
                                acc_next = INTEG_MAX;
                            end else if (asum < 19'(INTEG_MIN)) begin
                                acc_next = INTEG_MIN;
                            end else begin
                                acc_next = asum[17:0];
                            end
                            ew_next  = e;
                            dew_next = 4'(e) - 4'(prev_reg);
                            dtw_next = dt;
                            prev_next = e;
                        end
                    end
                end
            end
            OP_M1: a_next = 24'(ew_reg) * 24'($signed({1'b0, dtw_reg}));
            OP_M2: begin
                pa = 48'(a_reg) * 48'sd1000;
                a_next = pa[23:0];
            end
            OP_M3: begin
                pt = $signed({1'b0, cfg.gain_p}) * a_reg;
                t_next = NUM_W'(pt);
            end
            OP_M4: b_next = $signed({1'b0, cfg.gain_i}) * acc_reg;
            OP_M5: begin
                pb = b_reg * $signed({1'b0, dtw_reg});
                num_next = NUM_W'(pb);
            end
            OP_M6: begin
                num_next = num_reg + t_reg;
                c_next = $signed({1'b0, cfg.gain_d}) * dew_reg;
            end
            OP_M7: begin
                pc = c_reg * $signed(21'd1000000);
                t_next = NUM_W'(pc);
            end
            OP_M8: begin
                num_next = num_reg + t_reg;
                den_next = DEN_W'(27'd131072000) * DEN_W'(dtw_reg);
            end
            OP_DIV_INIT: begin
                neg_next = num_reg[NUM_W-1];
                dvd_next = num_reg[NUM_W-1] ? DVD_W'(-num_reg) : num_reg[DVD_W-1:0];
                rem_next = '0;
            end
            OP_DIV: begin
                rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_next = DEN_W'(rem_sh - {1'b0, den_reg});
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[DEN_W-1:0];
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                end
            end
            OP_FIN: begin
                qs = (|dvd_reg[DVD_W-1:9]) ? 9'h1FF : dvd_reg[8:0];
                corr = neg_reg ? -$signed({2'b00, qs}) : $signed({2'b00, qs});
                ls = bs - corr;
                rs = bs + corr;
                if (ls[10]) ls = 11'sd0;
                if (rs[10]) rs = 11'sd0;
                hd = drive_pack(ls, rs);
                held_next = hd;
                res_next  = make_out(hd, MODE_PID);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0; acc_reg <= '0; last_reg <= '0; have_reg <= 1'b0;
            search_reg <= 1'b0; lost_since_reg <= '0; lost_timing_reg <= 1'b0;
            start_reg <= '0; held_reg <= '{lf: 1'b1, ll: 8'd0, rf: 1'b1, rl: 8'd0};
            m_valid_reg <= 1'b0;
        end else begin
            prev_reg <= prev_next; acc_reg <= acc_next; last_reg <= last_next;
            have_reg <= have_next; search_reg <= search_next;
            lost_since_reg <= lost_since_next; lost_timing_reg <= lost_timing_next;
            start_reg <= start_next; held_reg <= held_next;
            m_valid_reg <= cmd.push | (m_valid_reg & ~m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next; res_reg <= res_next;
        ew_reg <= ew_next; dew_reg <= dew_next; dtw_reg <= dtw_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; t_reg <= t_next;
        num_reg <= num_next; den_reg <= den_next; dvd_reg <= dvd_next;
        rem_reg <= rem_next; neg_reg <= neg_next;
        if (cmd.push) m_item_reg <= res_reg;
    end

endmodule
`default_nettype wire

FILE: src/pid_line_follower_with_search_top.sv
// Top level of the PID line follower with search: config registers, sequencer, datapath.
// Depends on plf_pkg, plf_ctrl, plf_datapath.
//
//   channel   ports                          moves
//   input     s_valid s_ready s_item         samples, time, run enable
//   result    m_valid m_ready m_item         wheel command and mode
//   config    cfg_we cfg_index cfg_data      register write, no wait
//
// Halted, first-sample and search items go from evaluation straight to the result.
// PID items also pass through 8 multiply steps and a 53-step restoring divider.
// The output register lets the next item be accepted while a result waits.
// Reset is synchronous, active low; config takes its reset values.
`default_nettype none
module pid_line_follower_with_search_top import plf_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_item,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p          <= 24'd5898240;
            cfg_reg.gain_i          <= 24'd10486;
            cfg_reg.gain_d          <= 24'd1572864;
            cfg_reg.base_speed      <= 8'd50;
            cfg_reg.line_threshold  <= SAMPLE_BITS'(700);
            cfg_reg.line_is_lighter <= 1'b0;
            cfg_reg.search_enable   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAIN_P:    cfg_reg.gain_p          <= cfg_data;
                CFG_GAIN_I:    cfg_reg.gain_i          <= cfg_data;
                CFG_GAIN_D:    cfg_reg.gain_d          <= cfg_data;
                CFG_BASE:      cfg_reg.base_speed      <= cfg_data[7:0];
                CFG_THRESHOLD: cfg_reg.line_threshold  <= cfg_data[SAMPLE_BITS-1:0];
                CFG_LIGHTER:   cfg_reg.line_is_lighter <= cfg_data[0];
                CFG_SEARCH:    cfg_reg.search_enable   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    plf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    plf_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_item  (m_item),
        .m_ready (m_ready)
    );

endmodule
`default_nettype wire
